@@ design/uniform_block_counter_defines.svh @@
// assertion macros used by the uniform block counter
`ifndef UNIFORM_BLOCK_COUNTER_DEFINES_SVH
`define UNIFORM_BLOCK_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS
// a property checked on every clock edge outside reset
`define UBC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ubc assertion failed");
// an implication checked on every clock edge outside reset
`define UBC_ASSERT_IMPL(label, ante, cons) \
  `UBC_ASSERT(label, (ante) |-> (cons))
// a next-cycle implication checked outside reset
`define UBC_ASSERT_NEXT(label, ante, cons) \
  `UBC_ASSERT(label, (ante) |=> (cons))
`else
`define UBC_ASSERT(label, prop)
`define UBC_ASSERT_IMPL(label, ante, cons)
`define UBC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ design/ubc_pkg.sv @@
// constants, types and helpers for the uniform block counter
package ubc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SIZE_W  = 11;
  localparam int COUNT_W = 20;
  localparam int CFG_IDX_W = 2;

  // line store entry: {two rows above, row above}
  localparam int LINE_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [SIZE_W-1:0] SIZE_MIN       = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX_COLS  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] SIZE_MAX_ROWS  = SIZE_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] SIZE_RESET     = SIZE_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = CFG_IDX_W'(0),
    REG_FRAME_HEIGHT = CFG_IDX_W'(1)
  } cfg_reg_t;

  typedef logic [COUNT_W-1:0] count_t;

  // the four window counts of one frame
  typedef struct packed {
    count_t zero_2x2;
    count_t one_2x2;
    count_t zero_3x3;
    count_t one_3x3;
  } counts_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] top);
    logic [SIZE_W-1:0] res;
    begin
      if (v < SIZE_MIN) begin
        res = SIZE_MIN;
      end else if (v > top) begin
        res = top;
      end else begin
        res = v;
      end
      return res;
    end
  endfunction

  function automatic count_t bump(input count_t cnt);
    return (cnt == COUNT_MAX) ? cnt : cnt + COUNT_W'(1);
  endfunction

endpackage

@@ design/ubc_ifs.sv @@
// valid/ready channel interfaces for pixels, results and configuration
interface ubc_pix_if;
  logic valid;
  logic ready;
  logic pixel_bit;
  modport source(output valid, output pixel_bit, input ready);
  modport sink(input valid, input pixel_bit, output ready);
endinterface

interface ubc_res_if;
  logic                       valid;
  logic                       ready;
  logic [ubc_pkg::COUNT_W-1:0] zero_2x2_count;
  logic [ubc_pkg::COUNT_W-1:0] one_2x2_count;
  logic [ubc_pkg::COUNT_W-1:0] zero_3x3_count;
  logic [ubc_pkg::COUNT_W-1:0] one_3x3_count;
  modport source(output valid, output zero_2x2_count, output one_2x2_count,
                 output zero_3x3_count, output one_3x3_count, input ready);
  modport sink(input valid, input zero_2x2_count, input one_2x2_count,
               input zero_3x3_count, input one_3x3_count, output ready);
endinterface

interface ubc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ubc_pkg::CFG_IDX_W-1:0] index;
  logic [ubc_pkg::SIZE_W-1:0]    data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ design/ubc_ram.sv @@
// generic single-write, single-read ram with registered read data
module ubc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/uniform_block_counter.sv @@
// uniform block counter: counts all-zero and all-one 2x2 and 3x3 windows of a binary frame
//
// in_if takes one binary pixel per item in raster order; cfg_if writes frame_width
// (index 0) and frame_height (index 1), clamped to 2..1024; the user must write them only
// while the block is idle, which it does not enforce. After the last pixel of a frame
// out_if carries one item with the four window counts (saturating at 2^20-1), and the
// counters clear for the next frame. Only windows wholly inside the frame are counted.
//
// The two previous rows live in one 1024 x 2 line store ram. A pixel reads its
// column on acceptance and the updated column is written back when stage 1 fires, so
// one pixel is taken every cycle unless a held result stalls stage 1; consecutive
// pixels never share a column. A result is registered as the last pixel leaves stage 1.
// When the receiver stalls with a result still held, the block keeps taking
// pixels until the next frame's last pixel reaches the count stage, then holds
// in_if.ready low until the held result is taken.
// Reset clears positions, window and counts and sets both sizes to 10; the line
// store has no reset and needs none, as unwritten entries only reach uncounted windows.
module uniform_block_counter (
  input logic        clk,
  input logic        rst_n,
  ubc_pix_if.sink    in_if,
  ubc_res_if.source  out_if,
  ubc_cfg_if.sink    cfg_if
);

`include "uniform_block_counter_defines.svh"

  logic [ubc_pkg::SIZE_W-1:0] width_r, height_r;
  logic [ubc_pkg::SIZE_W-1:0] width_eff, height_eff;

  logic [ubc_pkg::COL_W-1:0] col_r, col_nxt;
  logic [ubc_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                      last_col, last_row;

  logic                      s1_v_r, s1_v_nxt;
  logic [ubc_pkg::COL_W-1:0] s1_col_r;
  logic [ubc_pkg::ROW_W-1:0] s1_row_r;
  logic                      s1_pix_r;
  logic                      s1_end_r;
  logic                      s1_fire;

  logic                      accept;
  logic [ubc_pkg::LINE_W-1:0] line_q;
  logic [2:0]                slice;
  logic [2:0]                prev, prev2;
  logic [5:0]                win_r;
  logic [3:0]                cells_small;
  logic [8:0]                cells_large;
  logic                      small_in, large_in;

  ubc_pkg::counts_t cnt_r, cnt_bumped, cnt_nxt;
  ubc_pkg::counts_t out_r;
  logic             out_valid_r, out_valid_nxt;

  // configuration
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ubc_pkg::SIZE_RESET;
      height_r <= ubc_pkg::SIZE_RESET;
    end else if (cfg_if.valid) begin
      case (ubc_pkg::cfg_reg_t'(cfg_if.index))
        ubc_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_if.data;
        ubc_pkg::REG_FRAME_HEIGHT: height_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign width_eff  = ubc_pkg::clamp_size(width_r, ubc_pkg::SIZE_MAX_COLS);
  assign height_eff = ubc_pkg::clamp_size(height_r, ubc_pkg::SIZE_MAX_ROWS);

  // stage 0: position tracking and line store read
  assign s1_fire = s1_v_r && !(s1_end_r && out_valid_r && !out_if.ready);
  assign in_if.ready = !s1_v_r || s1_fire;
  assign accept = in_if.valid && in_if.ready;

  assign last_col = (ubc_pkg::SIZE_W'(col_r) + ubc_pkg::SIZE_W'(1)) >= width_eff;
  assign last_row = (ubc_pkg::SIZE_W'(row_r) + ubc_pkg::SIZE_W'(1)) >= height_eff;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (!last_col) begin
        col_nxt = col_r + ubc_pkg::COL_W'(1);
      end else begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ubc_pkg::ROW_W'(1);
      end
    end
  end

  assign s1_v_nxt = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r <= col_r;
      s1_row_r <= row_r;
      s1_pix_r <= in_if.pixel_bit;
      s1_end_r <= last_col && last_row;
    end
  end

  // line store: bit 1 two rows above, bit 0 row above
  ubc_ram #(
    .WIDTH(ubc_pkg::LINE_W),
    .DEPTH(ubc_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col_r),
    .wdata ({line_q[0], s1_pix_r}),
    .re    (accept),
    .raddr (col_r),
    .rdata (line_q)
  );

  // stage 1: window test and counting
  assign slice = {line_q, s1_pix_r};
  assign prev  = win_r[2:0];
  assign prev2 = win_r[5:3];

  assign cells_small = {prev[1:0], slice[1:0]};
  assign cells_large = {prev2, prev, slice};
  assign small_in    = (s1_row_r != '0) && (s1_col_r != '0);
  assign large_in    = (s1_row_r > ubc_pkg::ROW_W'(1)) && (s1_col_r > ubc_pkg::COL_W'(1));

  always_comb begin
    cnt_bumped = cnt_r;
    if (small_in && (cells_small == '0)) begin
      cnt_bumped.zero_2x2 = ubc_pkg::bump(cnt_r.zero_2x2);
    end
    if (small_in && (cells_small == '1)) begin
      cnt_bumped.one_2x2 = ubc_pkg::bump(cnt_r.one_2x2);
    end
    if (large_in && (cells_large == '0)) begin
      cnt_bumped.zero_3x3 = ubc_pkg::bump(cnt_r.zero_3x3);
    end
    if (large_in && (cells_large == '1)) begin
      cnt_bumped.one_3x3 = ubc_pkg::bump(cnt_r.one_3x3);
    end
    cnt_nxt = s1_end_r ? '0 : cnt_bumped;
  end

  assign out_valid_nxt = (s1_fire && s1_end_r) ? 1'b1 :
                         (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        win_r <= {prev, slice};
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_end_r) begin
      out_r <= cnt_bumped;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.zero_2x2_count = out_r.zero_2x2;
  assign out_if.one_2x2_count  = out_r.one_2x2;
  assign out_if.zero_3x3_count = out_r.zero_3x3;
  assign out_if.one_3x3_count  = out_r.one_3x3;

  // checks
  `UBC_ASSERT_IMPL(a_no_same_col_rw, accept && s1_fire, col_r != s1_col_r)
  `UBC_ASSERT_IMPL(a_stall_only_on_held_result, s1_v_r && !s1_fire, out_valid_r && s1_end_r)
  `UBC_ASSERT_NEXT(a_counts_clear_after_frame, s1_fire && s1_end_r, cnt_r == '0)
  `UBC_ASSERT_IMPL(a_result_from_frame_end, $rose(out_valid_r), $past(s1_fire && s1_end_r))

endmodule
